/* design/pslh_pkg.sv */
// shared types, constants and the log2 bucket function of the latency histogram
package pslh_pkg;

  localparam int NUM_SITES   = 64;
  localparam int NUM_BUCKETS = 32;

  localparam int FUNC_W   = 2;
  localparam int SITE_IN_W = 6;
  localparam int WAIT_W   = 64;
  localparam int BSEL_W   = 5;
  localparam int STAT_W   = 64;

  localparam int SITE_W   = $clog2(NUM_SITES);
  localparam int BKT_W    = $clog2(NUM_BUCKETS);
  localparam int BADDR_W  = SITE_W + BKT_W;
  localparam int NFS_W    = $clog2(NUM_SITES + 1);
  localparam int MSB_W    = $clog2(WAIT_W);

  localparam int FIFO_DEPTH = 2;

  localparam logic [FUNC_W-1:0] FUNC_RECORD   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ     = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_REGISTER = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED   = 2'd3;

  typedef enum logic [1:0] {
    OP_RECORD,
    OP_READ,
    OP_REGISTER
  } op_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE
  } back_state_t;

  typedef struct packed {
    op_t                  op;
    logic [SITE_IN_W-1:0] site;
    logic [WAIT_W-1:0]    wait_cycles;
    logic [BKT_W-1:0]     bucket;
    logic                 site_ok;
    logic                 bkt_ok;
  } cmd_t;

  typedef struct packed {
    logic clearing;
    logic queue_full;
  } front_stat_t;

  // floor(log2(cycles)), zero maps to 0, clamped to the last bucket
  function automatic logic [BKT_W-1:0] bucket_of(input logic [WAIT_W-1:0] cycles);
    logic [WAIT_W-1:0] v;
    logic [MSB_W-1:0]  msb;
    v   = cycles;
    msb = '0;
    for (int i = MSB_W - 1; i >= 0; i--) begin
      if ((v >> (1 << i)) != '0) begin
        v   = v >> (1 << i);
        msb = msb | MSB_W'(1 << i);
      end
    end
    if (msb > MSB_W'(NUM_BUCKETS - 1)) begin
      msb = MSB_W'(NUM_BUCKETS - 1);
    end
    return msb[BKT_W-1:0];
  endfunction

endpackage

/* design/pslh_front.sv */
// front: accepts input beats, decodes the operation and computes the bucket
module pslh_front (
  input  logic                            push,
  output logic                            full,
  input  logic [pslh_pkg::FUNC_W-1:0]     in_func,
  input  logic [pslh_pkg::SITE_IN_W-1:0]  in_site,
  input  logic [pslh_pkg::WAIT_W-1:0]     in_wait_cycles,
  input  logic [pslh_pkg::BSEL_W-1:0]     in_bucket_select,
  input  pslh_pkg::front_stat_t           stat,
  output logic                            cmd_push,
  output pslh_pkg::cmd_t                  cmd
);
  import pslh_pkg::*;

  logic accept;
  logic keep;

  assign full   = stat.clearing | stat.queue_full;
  assign accept = push & ~full;

  always_comb begin
    cmd.site        = in_site;
    cmd.wait_cycles = in_wait_cycles;
    cmd.site_ok     = ({1'b0, in_site} < (SITE_IN_W + 1)'(NUM_SITES));
    cmd.bkt_ok      = ({1'b0, in_bucket_select} < (BSEL_W + 1)'(NUM_BUCKETS));
    cmd.op          = OP_RECORD;
    cmd.bucket      = bucket_of(in_wait_cycles);
    keep            = 1'b0;
    unique case (in_func)
      FUNC_RECORD: begin
        // records to sites beyond the table are dropped here
        keep = cmd.site_ok;
      end
      FUNC_READ: begin
        cmd.op     = OP_READ;
        cmd.bucket = in_bucket_select[BKT_W-1:0];
        keep       = 1'b1;
      end
      FUNC_REGISTER: begin
        cmd.op = OP_REGISTER;
        keep   = 1'b1;
      end
      FUNC_UNUSED: begin
        keep = 1'b0;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign cmd_push = accept & keep;

endmodule

/* design/pslh_cmd_fifo.sv */
// short command queue between front and back
module pslh_cmd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  pslh_pkg::cmd_t wr_data,
  input  logic           rd_en,
  output pslh_pkg::cmd_t rd_data,
  output logic           rd_valid,
  output logic           is_full
);
  import pslh_pkg::*;

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  cmd_t             mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign rd_valid = (cnt_r != '0);
  assign is_full  = (cnt_r == CNT_W'(FIFO_DEPTH));
  assign do_wr    = wr_en & ~is_full;
  assign do_rd    = rd_en & rd_valid;
  assign rd_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

/* design/pslh_back.sv */
// back: site statistics memories, update sequencer and result register
module pslh_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  pslh_pkg::cmd_t                  cmd,
  input  logic                            cmd_valid,
  output logic                            cmd_pop,
  output logic                            clearing,
  output logic                            empty,
  input  logic                            pop,
  output logic                            out_status,
  output logic [pslh_pkg::SITE_IN_W-1:0]  out_assigned_site,
  output logic                            out_is_registered,
  output logic [pslh_pkg::STAT_W-1:0]     out_event_count,
  output logic [pslh_pkg::STAT_W-1:0]     out_total_wait,
  output logic [pslh_pkg::STAT_W-1:0]     out_max_wait,
  output logic [pslh_pkg::STAT_W-1:0]     out_bucket_count
);
  import pslh_pkg::*;

  back_state_t           state_r, state_nxt;
  logic [BADDR_W-1:0]    clr_cnt_r, clr_cnt_nxt;
  logic [NFS_W-1:0]      next_free_r, next_free_nxt;
  logic [NUM_SITES-1:0]  site_reg_r;
  logic                  reg_set;
  cmd_t                  cur_r, cur_nxt;

  logic [STAT_W-1:0]     cnt_mem [NUM_SITES];
  logic [STAT_W-1:0]     tot_mem [NUM_SITES];
  logic [STAT_W-1:0]     max_mem [NUM_SITES];
  logic [STAT_W-1:0]     bkt_mem [NUM_SITES * NUM_BUCKETS];

  logic [STAT_W-1:0]     cnt_rd_r, tot_rd_r, max_rd_r, bkt_rd_r;
  logic                  flag_rd_r;

  logic [SITE_W-1:0]     rd_site, wr_site, cur_site;
  logic [BADDR_W-1:0]    rd_baddr, wr_baddr;
  logic                  wr_en;
  logic [STAT_W-1:0]     cnt_wd, tot_wd, max_wd, bkt_wd;

  logic                  out_valid_r, out_valid_nxt;
  logic                  out_free, load_out;
  logic                  status_r, status_nxt;
  logic [SITE_IN_W-1:0]  asite_r, asite_nxt;
  logic                  isreg_r, isreg_nxt;
  logic [STAT_W-1:0]     evc_r, evc_nxt;
  logic [STAT_W-1:0]     totw_r, totw_nxt;
  logic [STAT_W-1:0]     maxw_r, maxw_nxt;
  logic [STAT_W-1:0]     bktc_r, bktc_nxt;

  assign clearing = (state_r == ST_CLEAR);
  assign out_free = ~out_valid_r | pop;
  assign cur_site = cur_r.site[SITE_W-1:0];

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    next_free_nxt = next_free_r;
    cur_nxt       = cur_r;
    cmd_pop       = 1'b0;
    reg_set       = 1'b0;
    load_out      = 1'b0;
    status_nxt    = 1'b0;
    asite_nxt     = '0;
    isreg_nxt     = 1'b0;
    evc_nxt       = '0;
    totw_nxt      = '0;
    maxw_nxt      = '0;
    bktc_nxt      = '0;
    unique case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.op)
            OP_REGISTER: begin
              if (out_free) begin
                cmd_pop  = 1'b1;
                load_out = 1'b1;
                if (next_free_r == NFS_W'(NUM_SITES)) begin
                  status_nxt = 1'b1;
                end else begin
                  asite_nxt     = SITE_IN_W'(next_free_r[SITE_W-1:0]);
                  reg_set       = 1'b1;
                  next_free_nxt = next_free_r + 1'b1;
                end
              end
            end
            OP_READ: begin
              if (out_free) begin
                cmd_pop   = 1'b1;
                cur_nxt   = cmd;
                state_nxt = ST_UPDATE;
              end
            end
            OP_RECORD: begin
              cmd_pop   = 1'b1;
              cur_nxt   = cmd;
              state_nxt = ST_UPDATE;
            end
            default: begin
              cmd_pop = 1'b1;
            end
          endcase
        end
      end
      ST_UPDATE: begin
        state_nxt = ST_IDLE;
        if (cur_r.op == OP_READ) begin
          load_out = 1'b1;
          if (cur_r.site_ok) begin
            isreg_nxt = flag_rd_r;
            evc_nxt   = cnt_rd_r;
            totw_nxt  = tot_rd_r;
            maxw_nxt  = max_rd_r;
            bktc_nxt  = cur_r.bkt_ok ? bkt_rd_r : '0;
          end
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop && out_valid_r) begin
      out_valid_nxt = 1'b0;
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      next_free_r <= '0;
      site_reg_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      next_free_r <= next_free_nxt;
      out_valid_r <= out_valid_nxt;
      if (reg_set) begin
        site_reg_r[next_free_r[SITE_W-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (load_out) begin
      status_r <= status_nxt;
      asite_r  <= asite_nxt;
      isreg_r  <= isreg_nxt;
      evc_r    <= evc_nxt;
      totw_r   <= totw_nxt;
      maxw_r   <= maxw_nxt;
      bktc_r   <= bktc_nxt;
    end
  end

  // memory ports: clearing sweep or record write-back
  assign rd_site  = cmd.site[SITE_W-1:0];
  assign rd_baddr = {rd_site, cmd.bucket};
  assign wr_en    = clearing | ((state_r == ST_UPDATE) & (cur_r.op == OP_RECORD));
  assign wr_site  = clearing ? clr_cnt_r[SITE_W-1:0] : cur_site;
  assign wr_baddr = clearing ? clr_cnt_r : {cur_site, cur_r.bucket};
  assign cnt_wd   = clearing ? '0 : cnt_rd_r + 1'b1;
  assign tot_wd   = clearing ? '0 : tot_rd_r + cur_r.wait_cycles;
  assign max_wd   = clearing ? '0 :
                    ((cur_r.wait_cycles > max_rd_r) ? cur_r.wait_cycles : max_rd_r);
  assign bkt_wd   = clearing ? '0 : bkt_rd_r + 1'b1;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      cnt_mem[wr_site]  <= cnt_wd;
      tot_mem[wr_site]  <= tot_wd;
      max_mem[wr_site]  <= max_wd;
      bkt_mem[wr_baddr] <= bkt_wd;
    end
    cnt_rd_r  <= cnt_mem[rd_site];
    tot_rd_r  <= tot_mem[rd_site];
    max_rd_r  <= max_mem[rd_site];
    bkt_rd_r  <= bkt_mem[rd_baddr];
    flag_rd_r <= site_reg_r[rd_site];
  end

  assign empty             = ~out_valid_r;
  assign out_status        = status_r;
  assign out_assigned_site = asite_r;
  assign out_is_registered = isreg_r;
  assign out_event_count   = evc_r;
  assign out_total_wait    = totw_r;
  assign out_max_wait      = maxw_r;
  assign out_bucket_count  = bktc_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> (!out_valid_r || pop))
    else $error("result register overwritten before it was taken");

  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !cmd_pop)
    else $error("command taken during clearing sweep");

  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    next_free_r <= NFS_W'(NUM_SITES))
    else $error("next free site past the table");

  a_update_once: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPDATE) |=> (state_r == ST_IDLE))
    else $error("update step did not return to idle");

endmodule

/* design/per_site_latency_histogram.sv */
// top level of the per-site latency histogram: front, command queue, back
//
//   channel   handshake          payload
//   input     push / full        in_func, in_site, in_wait_cycles, in_bucket_select
//   result    empty / pop        out_status .. out_bucket_count (one beat per read/register)
//
// flow: the front takes one beat a cycle while full is low into a two-entry command queue;
//   the back handles a record or a read as a registered memory read, then a write-back
//   or result load, and a register directly in its idle state
// reset: a clearing sweep over all NUM_SITES*NUM_BUCKETS addresses (2048) zeroes the
//   statistics memories one address a cycle; full stays high until it ends
// stalls: a held result stops the back at the next read or register in the queue;
//   records ahead of it still drain, then the queue fills and full rises
module per_site_latency_histogram (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  output logic                            full,
  input  logic [pslh_pkg::FUNC_W-1:0]     in_func,
  input  logic [pslh_pkg::SITE_IN_W-1:0]  in_site,
  input  logic [pslh_pkg::WAIT_W-1:0]     in_wait_cycles,
  input  logic [pslh_pkg::BSEL_W-1:0]     in_bucket_select,
  output logic                            empty,
  input  logic                            pop,
  output logic                            out_status,
  output logic [pslh_pkg::SITE_IN_W-1:0]  out_assigned_site,
  output logic                            out_is_registered,
  output logic [pslh_pkg::STAT_W-1:0]     out_event_count,
  output logic [pslh_pkg::STAT_W-1:0]     out_total_wait,
  output logic [pslh_pkg::STAT_W-1:0]     out_max_wait,
  output logic [pslh_pkg::STAT_W-1:0]     out_bucket_count
);
  import pslh_pkg::*;

  // decoded command from the front into the queue
  cmd_t        front_cmd;
  logic        front_push;
  // queue head toward the back
  cmd_t        head_cmd;
  logic        head_valid;
  logic        head_pop;
  // status fed back to the front
  front_stat_t stat;
  logic        queue_full;
  logic        back_clearing;

  assign stat.clearing   = back_clearing;
  assign stat.queue_full = queue_full;

  // decode and bucket computation
  pslh_front u_front (
    .push             (push),
    .full             (full),
    .in_func          (in_func),
    .in_site          (in_site),
    .in_wait_cycles   (in_wait_cycles),
    .in_bucket_select (in_bucket_select),
    .stat             (stat),
    .cmd_push         (front_push),
    .cmd              (front_cmd)
  );

  // decouples acceptance from the memory sequencer
  pslh_cmd_fifo u_cmd_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (front_push),
    .wr_data  (front_cmd),
    .rd_en    (head_pop),
    .rd_data  (head_cmd),
    .rd_valid (head_valid),
    .is_full  (queue_full)
  );

  // statistics memories and result beat
  pslh_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (head_cmd),
    .cmd_valid         (head_valid),
    .cmd_pop           (head_pop),
    .clearing          (back_clearing),
    .empty             (empty),
    .pop               (pop),
    .out_status        (out_status),
    .out_assigned_site (out_assigned_site),
    .out_is_registered (out_is_registered),
    .out_event_count   (out_event_count),
    .out_total_wait    (out_total_wait),
    .out_max_wait      (out_max_wait),
    .out_bucket_count  (out_bucket_count)
  );

endmodule

/* tb/tb_per_site_latency_histogram.sv */
// self-checking testbench of the per-site latency histogram
module tb_per_site_latency_histogram;
  timeunit 1ns;
  timeprecision 1ps;

  import pslh_pkg::*;

  // random items, unused func codes included
  localparam int RANDOM_ITEMS = 1228;
  // cycles with no beat on either side before the run is called hung;
  // covers the clearing sweep and the long receiver hold-off
  localparam int QUIET_LIMIT  = 20000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [FUNC_W-1:0]    func;
    logic [SITE_IN_W-1:0] site;
    logic [WAIT_W-1:0]    wait_c;
    logic [BSEL_W-1:0]    bsel;
  } cmd_beat_t;

  typedef struct packed {
    logic                 status;
    logic [SITE_IN_W-1:0] assigned_site;
    logic                 is_registered;
    logic [STAT_W-1:0]    event_count;
    logic [STAT_W-1:0]    total_wait;
    logic [STAT_W-1:0]    max_wait;
    logic [STAT_W-1:0]    bucket_count;
  } answer_t;

  // one row of the directed table; typed rows carry their answer literally
  typedef struct packed {
    cmd_beat_t cmd;
    bit        typed;
    answer_t   ans;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic [FUNC_W-1:0]    in_func = '0;
  logic [SITE_IN_W-1:0] in_site = '0;
  logic [WAIT_W-1:0]    in_wait_cycles = '0;
  logic [BSEL_W-1:0]    in_bucket_select = '0;
  logic                 full;
  logic                 empty;
  logic                 out_status;
  logic [SITE_IN_W-1:0] out_assigned_site;
  logic                 out_is_registered;
  logic [STAT_W-1:0]    out_event_count;
  logic [STAT_W-1:0]    out_total_wait;
  logic [STAT_W-1:0]    out_max_wait;
  logic [STAT_W-1:0]    out_bucket_count;

  // idle percentages of both sides, switched by the stimulus as it goes
  int unsigned tx_idle_pct = 37;
  int unsigned rx_idle_pct = 87;
  // receiver hold-off, asked for by the sender, counted by the receiver
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned hold_left = 0;

  int unsigned fail_count = 0;
  int unsigned quiet_cycles = 0;

  // predicted site table, all zero after reset
  int unsigned next_site = 0;
  bit          site_taken [NUM_SITES];
  bit [63:0]   hits [NUM_SITES];
  bit [63:0]   wait_sum [NUM_SITES];
  bit [63:0]   wait_peak [NUM_SITES];
  bit [63:0]   bucket_hits [NUM_SITES][NUM_BUCKETS];

  // answers still owed by the block, oldest first
  answer_t pending_answers[$];
  dir_row_t directed_rows[$];

  per_site_latency_histogram u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_func          (in_func),
    .in_site          (in_site),
    .in_wait_cycles   (in_wait_cycles),
    .in_bucket_select (in_bucket_select),
    .empty            (empty),
    .pop              (pop),
    .out_status       (out_status),
    .out_assigned_site(out_assigned_site),
    .out_is_registered(out_is_registered),
    .out_event_count  (out_event_count),
    .out_total_wait   (out_total_wait),
    .out_max_wait     (out_max_wait),
    .out_bucket_count (out_bucket_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // index of the highest set bit, zero for 0 and 1, clamped to the last bucket
  function automatic int unsigned log2_bucket(input bit [63:0] w);
    int unsigned top;
    top = 0;
    for (int i = 1; i < 64; i++) begin
      if (w[i]) top = i;
    end
    return (top > NUM_BUCKETS - 1) ? NUM_BUCKETS - 1 : top;
  endfunction

  // applies one accepted beat to the predicted site table
  task automatic site_table_step(input cmd_beat_t c, output bit has_answer,
                                 output answer_t a);
    int unsigned b;
    a = '0;
    has_answer = 1'b0;
    case (c.func)
      FUNC_RECORD: begin
        // unregistered sites are updated too
        if (int'(c.site) < NUM_SITES) begin
          b = log2_bucket(c.wait_c);
          hits[c.site] += 64'd1;
          wait_sum[c.site] += c.wait_c;
          if (c.wait_c > wait_peak[c.site]) wait_peak[c.site] = c.wait_c;
          bucket_hits[c.site][b] += 64'd1;
        end
      end
      FUNC_READ: begin
        has_answer = 1'b1;
        if (int'(c.site) < NUM_SITES) begin
          a.is_registered = site_taken[c.site];
          a.event_count   = hits[c.site];
          a.total_wait    = wait_sum[c.site];
          a.max_wait      = wait_peak[c.site];
          if (int'(c.bsel) < NUM_BUCKETS) a.bucket_count = bucket_hits[c.site][c.bsel];
        end
      end
      FUNC_REGISTER: begin
        has_answer = 1'b1;
        // table full: refused, index stays at the end
        if (next_site >= NUM_SITES) begin
          a.status = 1'b1;
        end else begin
          site_taken[next_site] = 1'b1;
          a.assigned_site = SITE_IN_W'(next_site);
          next_site++;
        end
      end
      default: ; // unused code: no answer, no change
    endcase
  endtask

  function automatic cmd_beat_t random_beat();
    cmd_beat_t c;
    int unsigned pick;
    int unsigned span;
    pick = $urandom_range(99);
    if (pick < 50) c.func = FUNC_RECORD;
    else if (pick < 80) c.func = FUNC_READ;
    else if (pick < 92) c.func = FUNC_REGISTER;
    else c.func = FUNC_UNUSED;
    // a few hot sites so back-to-back updates hit the same entry
    c.site = ($urandom_range(3) != 0) ? SITE_IN_W'($urandom_range(3))
                                      : SITE_IN_W'($urandom_range(NUM_SITES - 1));
    // wait lengths spread over every bit width, with exact bucket edges now and then
    span = $urandom_range(64);
    c.wait_c = {$urandom, $urandom};
    if ($urandom_range(9) == 0) begin
      c.wait_c = (64'd1 << span) - 64'($urandom_range(1));
    end else if ($urandom_range(7) != 0) begin
      c.wait_c = (span == 0) ? '0 : c.wait_c >> (64 - span);
    end
    // half of the reads land on a bucket that records actually fill
    c.bsel = ($urandom_range(1) != 0) ? BSEL_W'($urandom_range(NUM_BUCKETS - 1))
                                      : BSEL_W'(log2_bucket(c.wait_c));
    return c;
  endfunction

  function automatic void add_row(input logic [FUNC_W-1:0] func,
                                  input logic [SITE_IN_W-1:0] site,
                                  input logic [WAIT_W-1:0] wait_c,
                                  input logic [BSEL_W-1:0] bsel,
                                  input bit typed, input answer_t ans);
    dir_row_t r;
    r.cmd.func   = func;
    r.cmd.site   = site;
    r.cmd.wait_c = wait_c;
    r.cmd.bsel   = bsel;
    r.typed      = typed;
    r.ans        = ans;
    directed_rows.push_back(r);
  endfunction

  // offers one beat until accepted, predicts it, then idles at random
  task automatic offer_beat(input cmd_beat_t c, input bit typed, input answer_t ans);
    bit      has_answer;
    answer_t predicted;
    push             <= 1'b1;
    in_func          <= c.func;
    in_site          <= c.site;
    in_wait_cycles   <= c.wait_c;
    in_bucket_select <= c.bsel;
    do @(posedge clk); while (full);
    site_table_step(c, has_answer, predicted);
    if (has_answer) pending_answers.push_back(typed ? ans : predicted);
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
  endtask

  function automatic void check_field(input string what, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      fail_count++;
    end
  endfunction

  // result side: checks every beat taken, stalls at random, holds off once
  always @(posedge clk) begin
    answer_t want;
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (pending_answers.size() == 0) begin
          $display("%0t: result beat mismatch, expected no beat, actual status %0h site %0h",
                   $time, out_status, out_assigned_site);
          fail_count++;
        end else begin
          want = pending_answers.pop_front();
          check_field("status", 64'(want.status), 64'(out_status));
          check_field("assigned_site", 64'(want.assigned_site), 64'(out_assigned_site));
          check_field("is_registered", 64'(want.is_registered), 64'(out_is_registered));
          check_field("event_count", want.event_count, out_event_count);
          check_field("total_wait", want.total_wait, out_total_wait);
          check_field("max_wait", want.max_wait, out_max_wait);
          check_field("bucket_count", want.bucket_count, out_bucket_count);
        end
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        pop       <= 1'b0;
      end else if (hold_req && !hold_done) begin
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
        pop       <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // watchdog: too long without a beat on either side means a hang
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    answer_t   none;
    answer_t   reg0;
    answer_t   reg1;
    answer_t   seen1;
    cmd_beat_t c;
    int unsigned counted;

    none  = '0;
    reg0  = '0;
    reg1  = '0;
    reg1.assigned_site = 1;
    seen1 = '0;
    seen1.is_registered = 1'b1;

    // directed table: func, site, wait, bucket select, typed, answer
    // empty table right after reset, both ends of the site and bucket range
    add_row(FUNC_READ,     6'd0,  64'd0, 5'd0,  1'b1, none);
    add_row(FUNC_READ,     6'd63, 64'd0, 5'd31, 1'b1, none);
    // first two registers hand out 0 and 1; site field is don't-care
    add_row(FUNC_REGISTER, 6'd63, 64'd0, 5'd31, 1'b1, reg0);
    add_row(FUNC_REGISTER, 6'd0,  64'd0, 5'd0,  1'b1, reg1);
    // zero and one both land in bucket 0, then bucket edges and the clamp
    add_row(FUNC_RECORD,   6'd0,  64'd0, 5'd0,  1'b0, none);
    add_row(FUNC_RECORD,   6'd0,  64'd1, 5'd0,  1'b0, none);
    add_row(FUNC_RECORD,   6'd0,  64'd2, 5'd0,  1'b0, none);
    add_row(FUNC_RECORD,   6'd0,  64'h4000_0000, 5'd0, 1'b0, none);
    add_row(FUNC_RECORD,   6'd0,  64'h8000_0000, 5'd0, 1'b0, none);
    add_row(FUNC_RECORD,   6'd0,  '1,    5'd0,  1'b0, none);
    add_row(FUNC_READ,     6'd0,  64'd0, 5'd0,  1'b0, none);
    add_row(FUNC_READ,     6'd0,  64'd0, 5'd30, 1'b0, none);
    add_row(FUNC_READ,     6'd0,  64'd0, 5'd31, 1'b0, none);
    // unused func code: no answer, nothing changes
    add_row(FUNC_UNUSED,   6'd0,  '1,    5'd31, 1'b0, none);
    add_row(FUNC_READ,     6'd0,  '1,    5'd31, 1'b0, none);
    // never-registered site still counts; total wraps past 2^64
    add_row(FUNC_RECORD,   6'd63, '1,    5'd31, 1'b0, none);
    add_row(FUNC_RECORD,   6'd63, '1,    5'd31, 1'b0, none);
    add_row(FUNC_READ,     6'd63, 64'd0, 5'd31, 1'b0, none);
    // registered but nothing recorded
    add_row(FUNC_READ,     6'd1,  64'd0, 5'd1,  1'b1, seen1);
    add_row(FUNC_RECORD,   6'd42, 64'd3, 5'd21, 1'b0, none);
    add_row(FUNC_READ,     6'd42, 64'd0, 5'd1,  1'b0, none);
    add_row(FUNC_READ,     6'd0,  64'd0, 5'd21, 1'b0, none);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      offer_beat(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].ans);
    end

    // random part in three idle phases; the last one also holds the receiver off
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      if (counted == RANDOM_ITEMS / 3) begin
        tx_idle_pct = 87;
        rx_idle_pct = 37;
      end else if (counted == 2 * RANDOM_ITEMS / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_req <= 1'b1;
      end
      c = random_beat();
      offer_beat(c, 1'b0, none);
      counted++;
    end
    push <= 1'b0;

    // drain what is still owed, then give stray beats a chance to show up
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
